[rtl/bsaf_pkg.sv]
// ----------------------------------------------------------------------------
// bsaf_pkg
// Types and codes for the data-processing ALU with barrel shifter.
// ----------------------------------------------------------------------------
package bsaf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AmtW  = 6;   // shift amounts 0..33 after clamping

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } alu_op_e;

  typedef enum logic [1:0] {
    KIND_LSL = 2'd0,
    KIND_LSR = 2'd1,
    KIND_ASR = 2'd2,
    KIND_ROR = 2'd3
  } shift_kind_e;

  // Normalized shifter operation after decode
  typedef enum logic [2:0] {
    SH_NONE = 3'd0,
    SH_LSL  = 3'd1,
    SH_LSR  = 3'd2,
    SH_ASR  = 3'd3,
    SH_ROR  = 3'd4,
    SH_RRX  = 3'd5
  } shift_op_e;

  typedef struct packed {
    logic [3:0]       func;
    logic             set_flags;
    logic             imm_form;
    logic [7:0]       imm_byte;
    logic [3:0]       imm_rotate;
    logic             shift_by_reg;
    logic [1:0]       shift_kind;
    logic [4:0]       shift_imm;
    logic [DataW-1:0] first_operand;
    logic [DataW-1:0] shifted_operand;
    logic [7:0]       shift_reg_byte;
    logic             carry_in;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             writes_result;
    logic             flags_write;
    logic             flag_n;
    logic             flag_z;
    logic             flag_c;
    logic             v_write;
    logic             flag_v;
  } out_t;

  // Fields carried alongside the datapath
  typedef struct packed {
    logic [3:0]       func;
    logic             set_flags;
    logic [DataW-1:0] first_operand;
    logic             carry_in;
  } side_t;

  // After decode: shifter source and normalized control
  typedef struct packed {
    side_t            side;
    logic [DataW-1:0] src;
    shift_op_e        op;
    logic [AmtW-1:0]  amt;
  } dec_t;

  // After the shifter: second operand and shifter carry
  typedef struct packed {
    side_t            side;
    logic [DataW-1:0] op_b;
    logic             sh_carry;
  } shf_t;

  // After the ALU
  typedef struct packed {
    logic [3:0]       func;
    logic             set_flags;
    logic             carry_in;
    logic [DataW-1:0] res;
    logic             carry;
    logic             ovf;
    logic             arith;
  } alu_t;

endpackage

[rtl/barrel_shifter_alu_flags.sv]
// ----------------------------------------------------------------------------
// barrel_shifter_alu_flags
// Four-stage data-processing ALU: operand-two decode, barrel shifter,
// 32-bit ALU, flag generation.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------
//   in      | input     | in_valid_i / in_ready_o    | in_data_i  (in_t)
//   out     | output    | out_valid_o / out_ready_i  | out_data_o (out_t)
//
// One transaction per cycle sustained while out_ready_i is high. Each transaction
// crosses four register stages (decode, shift, ALU, flag register) before
// out_valid_o rises.
// The adder carry chain in the ALU stage and the 32-bit shifter set the clock.
// Reset clears the stage valid bits only; the datapath registers are not reset.
// A stage holds while the next one is full and stalled, and each stage fills
// its own bubble, so back-pressure drops and repeats nothing.
//
module barrel_shifter_alu_flags
  import bsaf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // Stage valid bits and stage enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  // Advance a stage whenever it is empty or its content moves on
  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: decode operand two into a shifter op with a clamped amount.
  // Out-of-range amounts are folded so the shifter needs no special cases:
  // LSL/LSR above 32 clamp to 33 (all zero, carry 0), ASR clamps to 32,
  // ROR keeps the amount modulo 32.
  // --------------------------------------------------------------------------
  dec_t dec_d, dec_q;

  always_comb begin
    dec_d.side.func          = in_data_i.func;
    dec_d.side.set_flags     = in_data_i.set_flags;
    dec_d.side.first_operand = in_data_i.first_operand;
    dec_d.side.carry_in      = in_data_i.carry_in;
    dec_d.src                = in_data_i.shifted_operand;
    dec_d.op                 = SH_NONE;
    dec_d.amt                = '0;

    if (in_data_i.imm_form) begin
      // Rotated immediate; a zero rotate leaves the carry untouched
      dec_d.src = {{(DataW-8){1'b0}}, in_data_i.imm_byte};
      dec_d.amt = {1'b0, in_data_i.imm_rotate, 1'b0};
      dec_d.op  = (in_data_i.imm_rotate == 4'd0) ? SH_NONE : SH_ROR;
    end else if (in_data_i.shift_by_reg) begin
      if (in_data_i.shift_reg_byte != 8'd0) begin
        case (shift_kind_e'(in_data_i.shift_kind))
          KIND_LSL: begin
            dec_d.op  = SH_LSL;
            dec_d.amt = (in_data_i.shift_reg_byte > 8'd32) ? AmtW'(33)
                                                           : in_data_i.shift_reg_byte[5:0];
          end
          KIND_LSR: begin
            dec_d.op  = SH_LSR;
            dec_d.amt = (in_data_i.shift_reg_byte > 8'd32) ? AmtW'(33)
                                                           : in_data_i.shift_reg_byte[5:0];
          end
          KIND_ASR: begin
            dec_d.op  = SH_ASR;
            dec_d.amt = (in_data_i.shift_reg_byte > 8'd32) ? AmtW'(32)
                                                           : in_data_i.shift_reg_byte[5:0];
          end
          default: begin
            dec_d.op  = SH_ROR;
            dec_d.amt = {1'b0, in_data_i.shift_reg_byte[4:0]};
          end
        endcase
      end
    end else begin
      if (in_data_i.shift_imm == 5'd0) begin
        // Zero immediate: LSL passes, LSR/ASR mean 32, ROR means RRX
        case (shift_kind_e'(in_data_i.shift_kind))
          KIND_LSL: dec_d.op = SH_NONE;
          KIND_LSR: begin
            dec_d.op  = SH_LSR;
            dec_d.amt = AmtW'(32);
          end
          KIND_ASR: begin
            dec_d.op  = SH_ASR;
            dec_d.amt = AmtW'(32);
          end
          default:  dec_d.op = SH_RRX;
        endcase
      end else begin
        dec_d.amt = {1'b0, in_data_i.shift_imm};
        case (shift_kind_e'(in_data_i.shift_kind))
          KIND_LSL: dec_d.op = SH_LSL;
          KIND_LSR: dec_d.op = SH_LSR;
          KIND_ASR: dec_d.op = SH_ASR;
          default:  dec_d.op = SH_ROR;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) dec_q <= dec_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2: barrel shifter. Shift one guard bit along to pick up the carry.
  // --------------------------------------------------------------------------
  shf_t shf_d, shf_q;

  logic        [DataW:0]     lsl_w;
  logic        [DataW:0]     lsr_w;
  logic signed [DataW:0]     asr_w;
  logic        [2*DataW-1:0] ror_w;

  assign lsl_w = {1'b0, dec_q.src} << dec_q.amt;
  assign lsr_w = {dec_q.src, 1'b0} >> dec_q.amt;
  assign asr_w = $signed({dec_q.src, 1'b0}) >>> dec_q.amt;
  assign ror_w = {dec_q.src, dec_q.src} >> dec_q.amt[4:0];

  always_comb begin
    shf_d.side = dec_q.side;
    case (dec_q.op)
      SH_LSL: begin
        shf_d.op_b     = lsl_w[DataW-1:0];
        shf_d.sh_carry = lsl_w[DataW];
      end
      SH_LSR: begin
        shf_d.op_b     = lsr_w[DataW:1];
        shf_d.sh_carry = lsr_w[0];
      end
      SH_ASR: begin
        shf_d.op_b     = asr_w[DataW:1];
        shf_d.sh_carry = asr_w[0];
      end
      SH_ROR: begin
        shf_d.op_b     = ror_w[DataW-1:0];
        shf_d.sh_carry = ror_w[DataW-1];
      end
      SH_RRX: begin
        shf_d.op_b     = {dec_q.side.carry_in, dec_q.src[DataW-1:1]};
        shf_d.sh_carry = dec_q.src[0];
      end
      default: begin
        shf_d.op_b     = dec_q.src;
        shf_d.sh_carry = dec_q.side.carry_in;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2) shf_q <= shf_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: ALU. SUB, RSB and CMP run as x + ~y + 1 on one adder; SBC and RSC use the carry in place of the 1.
  // --------------------------------------------------------------------------
  alu_t             alu_d, alu_q;
  logic [DataW-1:0] add_x, add_y, a_op, b_op, logic_res;
  logic             add_ci;
  logic             alu_arith;
  logic [DataW:0]   sum_w;

  assign a_op = shf_q.side.first_operand;
  assign b_op = shf_q.op_b;

  always_comb begin
    add_x     = a_op;
    add_y     = b_op;
    add_ci    = 1'b0;
    logic_res = '0;
    alu_arith = 1'b1;
    case (alu_op_e'(shf_q.side.func))
      OP_AND, OP_TST: begin
        alu_arith = 1'b0;
        logic_res = a_op & b_op;
      end
      OP_EOR, OP_TEQ: begin
        alu_arith = 1'b0;
        logic_res = a_op ^ b_op;
      end
      OP_ORR: begin
        alu_arith = 1'b0;
        logic_res = a_op | b_op;
      end
      OP_MOV: begin
        alu_arith = 1'b0;
        logic_res = b_op;
      end
      OP_BIC: begin
        alu_arith = 1'b0;
        logic_res = a_op & ~b_op;
      end
      OP_MVN: begin
        alu_arith = 1'b0;
        logic_res = ~b_op;
      end
      OP_SUB, OP_CMP: begin
        add_y  = ~b_op;
        add_ci = 1'b1;
      end
      OP_RSB: begin
        add_x  = ~a_op;
        add_ci = 1'b1;
      end
      OP_ADD, OP_CMN: add_ci = 1'b0;
      OP_ADC: add_ci = shf_q.side.carry_in;
      OP_SBC: begin
        add_y  = ~b_op;
        add_ci = shf_q.side.carry_in;
      end
      default: begin  // RSC
        add_x  = ~a_op;
        add_ci = shf_q.side.carry_in;
      end
    endcase
  end

  assign sum_w = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_ci};

  always_comb begin
    alu_d.func      = shf_q.side.func;
    alu_d.set_flags = shf_q.side.set_flags;
    alu_d.carry_in  = shf_q.side.carry_in;
    alu_d.arith     = alu_arith;
    if (alu_arith) begin
      alu_d.res   = sum_w[DataW-1:0];
      alu_d.carry = sum_w[DataW];
      alu_d.ovf   = (sum_w[DataW-1] ^ add_x[DataW-1]) & (sum_w[DataW-1] ^ add_y[DataW-1]);
    end else begin
      alu_d.res   = logic_res;
      alu_d.carry = shf_q.sh_carry;
      alu_d.ovf   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) alu_q <= alu_d;
  end

  // --------------------------------------------------------------------------
  // Stage 4: flags and output register. Test and compare ops force S and
  // drop the writeback.
  // --------------------------------------------------------------------------
  out_t out_d, out_q;
  logic is_test, fw;

  assign is_test = (alu_q.func[3:2] == 2'b10);
  assign fw      = is_test || alu_q.set_flags;

  always_comb begin
    out_d.result        = alu_q.res;
    out_d.writes_result = !is_test;
    out_d.flags_write   = fw;
    out_d.flag_n        = alu_q.res[DataW-1];
    out_d.flag_z        = (alu_q.res == '0);
    out_d.flag_c        = fw ? alu_q.carry : alu_q.carry_in;
    out_d.v_write       = alu_q.arith && fw;
    out_d.flag_v        = alu_q.ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en4) out_q <= out_d;
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

endmodule
